@@ design/separable_sine_series_pixel_defines.svh @@
// Assertion macros for the separable sine-series pixel block.
// Used by the port checker; relies on clock and reset being in scope.
`ifndef SEPARABLE_SINE_SERIES_PIXEL_DEFINES_SVH
`define SEPARABLE_SINE_SERIES_PIXEL_DEFINES_SVH

// Checked outside reset only.
`define SSP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define SSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/ssp_pkg.sv @@
// Shared constants, types and functions of the sine-series pixel block.
// No dependencies; used by ssp_sine_rom and separable_sine_series_pixel.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

   localparam int PHASE_W     = 17;
   localparam int COORD_W     = 12;
   localparam int COEF_W      = 16;
   localparam int OUT_W       = 20;
   localparam int TERMS       = 3;
   localparam int COEF_REGS   = 3;
   localparam int SINE_DEPTH  = 1024;
   localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
   localparam int SINE_ADDR_W = SINE_IDX_W + 1;
   localparam int SINE_W      = 15;
   localparam int PROD_W      = COEF_W + SINE_W + 1;
   localparam int SER_W       = PROD_W + $clog2(TERMS + 1);
   localparam int TOT_W       = SER_W + 1;
   localparam int FRAC_SHIFT  = SINE_W;
   localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN     = -(1 << (OUT_W - 1));
   localparam int REQ_W       = 24;
   localparam int RSP_W       = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      REG_X_STEP  = 3'd0,
      REG_Y_STEP  = 3'd1,
      REG_X_COEF1 = 3'd2,
      REG_X_COEF2 = 3'd3,
      REG_X_COEF3 = 3'd4,
      REG_Y_COEF1 = 3'd5,
      REG_Y_COEF2 = 3'd6,
      REG_Y_COEF3 = 3'd7
   } reg_idx_type;

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_DEPTH];

   // Quarter-wave sine, unsigned Q0.15, from an integer Taylor series in Q30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] q;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
         term = x;
         acc  = x;
         for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         q = (acc + 64'd16384) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         rom[i] = q[SINE_W-1:0];
      end
      return rom;
   endfunction

   // Table address for one phase: quadrant 1 and 3 read the mirrored entry.
   function automatic logic [SINE_ADDR_W-1:0] sine_addr(input logic [PHASE_W-1:0] angle);
      logic [SINE_ADDR_W-1:0] idx;
      idx = {1'b0, angle[PHASE_W-3 -: SINE_IDX_W]};
      if (angle[PHASE_W-2]) begin
         return SINE_ADDR_W'(SINE_DEPTH) - idx;
      end else begin
         return idx;
      end
   endfunction

endpackage

`default_nettype wire

@@ design/ssp_sine_rom.sv @@
// Two-port quarter-wave sine ROM with registered read data.
// Depends on ssp_pkg for the table contents and widths.
`timescale 1ns / 1ps
`default_nettype none

module ssp_sine_rom (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [ssp_pkg::SINE_ADDR_W-1:0] addr_a,
   input  wire logic [ssp_pkg::SINE_ADDR_W-1:0] addr_b,
   output logic      [ssp_pkg::SINE_W-1:0]      data_a,
   output logic      [ssp_pkg::SINE_W-1:0]      data_b
);

   localparam ssp_pkg::sine_rom_type SINE_ROM = ssp_pkg::build_sine_rom();

   logic [ssp_pkg::SINE_W-1:0] data_a_ff;
   logic [ssp_pkg::SINE_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

`default_nettype wire

@@ design/separable_sine_series_pixel.sv @@
// Top level of the separable sine-series pixel generator.
// Depends on ssp_pkg and ssp_sine_rom.
//
// Usage:
//   req channel: one beat per pixel, tdata = {pixel_col, pixel_row}.
//   rsp channel: one beat per pixel, tdata = pixel_value (signed Q12.8, saturated).
//   csr port: APB-style writes/reads of the phase steps and the six coefficients,
//   register i at byte address 4*i; write only while no pixel is in flight.
// Throughput: one pixel per clock while rsp is not stalled. Five register stages: phase multiply,
//   sine table read, coefficient multiply, per-axis sum, round and saturate.
//   Each harmonic has its own table with two read ports (column and row),
//   so all six lookups of a pixel happen in the same cycle.
// Path: an accepted beat passes stages 1 to 4 and the output register before it shows on rsp.
// Reset: synchronous; empties the pipeline and clears the configuration registers to zero.
// Back-pressure: each stage holds while the one after it is full and stalled;
//   empty stages still fill, so req_tready drops only when all five are full.
`timescale 1ns / 1ps
`default_nettype none

module separable_sine_series_pixel (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // [11:0] pixel_row, [23:12] pixel_col
   input  wire logic [ssp_pkg::REQ_W-1:0]         req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [19:0] pixel_value, [23:20] zero
   output logic      [ssp_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ssp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ssp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int MUL_W = ssp_pkg::PHASE_W + ssp_pkg::COORD_W;

   // ---------------- configuration registers ----------------
   logic        [ssp_pkg::PHASE_W-1:0] x_step_ff;
   logic        [ssp_pkg::PHASE_W-1:0] y_step_ff;
   logic signed [ssp_pkg::COEF_W-1:0]  x_coef_ff [ssp_pkg::COEF_REGS];
   logic signed [ssp_pkg::COEF_W-1:0]  y_coef_ff [ssp_pkg::COEF_REGS];

   ssp_pkg::reg_idx_type csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = ssp_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_step_ff <= '0;
         y_step_ff <= '0;
         for (int i = 0; i < ssp_pkg::COEF_REGS; i++) begin
            x_coef_ff[i] <= '0;
            y_coef_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            ssp_pkg::REG_X_STEP:  x_step_ff    <= csr_pwdata[ssp_pkg::PHASE_W-1:0];
            ssp_pkg::REG_Y_STEP:  y_step_ff    <= csr_pwdata[ssp_pkg::PHASE_W-1:0];
            ssp_pkg::REG_X_COEF1: x_coef_ff[0] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
            ssp_pkg::REG_X_COEF2: x_coef_ff[1] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
            ssp_pkg::REG_X_COEF3: x_coef_ff[2] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
            ssp_pkg::REG_Y_COEF1: y_coef_ff[0] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
            ssp_pkg::REG_Y_COEF2: y_coef_ff[1] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
            ssp_pkg::REG_Y_COEF3: y_coef_ff[2] <= csr_pwdata[ssp_pkg::COEF_W-1:0];
         endcase
      end
   end

   function automatic logic [ssp_pkg::CSR_DATA_W-1:0] CSR_DATA_W_EXT(
      input logic [ssp_pkg::PHASE_W-1:0] v);
      return {{(ssp_pkg::CSR_DATA_W - ssp_pkg::PHASE_W){1'b0}}, v};
   endfunction

   always_comb begin
      unique case (csr_idx)
         ssp_pkg::REG_X_STEP:  csr_prdata = CSR_DATA_W_EXT(x_step_ff);
         ssp_pkg::REG_Y_STEP:  csr_prdata = CSR_DATA_W_EXT(y_step_ff);
         ssp_pkg::REG_X_COEF1: csr_prdata = {16'd0, x_coef_ff[0]};
         ssp_pkg::REG_X_COEF2: csr_prdata = {16'd0, x_coef_ff[1]};
         ssp_pkg::REG_X_COEF3: csr_prdata = {16'd0, x_coef_ff[2]};
         ssp_pkg::REG_Y_COEF1: csr_prdata = {16'd0, y_coef_ff[0]};
         ssp_pkg::REG_Y_COEF2: csr_prdata = {16'd0, y_coef_ff[1]};
         ssp_pkg::REG_Y_COEF3: csr_prdata = {16'd0, y_coef_ff[2]};
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, out_en;

   assign out_en     = !out_valid_ff || rsp_tready;
   assign s4_en      = !s4_valid_ff || out_en;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_valid_ff  <= req_tvalid;
         if (s2_en)  s2_valid_ff  <= s1_valid_ff;
         if (s3_en)  s3_valid_ff  <= s2_valid_ff;
         if (s4_en)  s4_valid_ff  <= s3_valid_ff;
         if (out_en) out_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 1: base phase = step * coord mod 2pi ----------------
   logic [ssp_pkg::COORD_W-1:0] pixel_row, pixel_col;
   logic [MUL_W-1:0]            x_mul, y_mul;
   logic [ssp_pkg::PHASE_W-1:0] x_base_ff, y_base_ff;

   assign pixel_row = req_tdata[ssp_pkg::COORD_W-1:0];
   assign pixel_col = req_tdata[2*ssp_pkg::COORD_W-1:ssp_pkg::COORD_W];
   assign x_mul     = MUL_W'(x_step_ff) * MUL_W'(pixel_col);
   assign y_mul     = MUL_W'(y_step_ff) * MUL_W'(pixel_row);

   always_ff @(posedge clock) begin
      if (s1_en) begin
         x_base_ff <= x_mul[ssp_pkg::PHASE_W-1:0];
         y_base_ff <= y_mul[ssp_pkg::PHASE_W-1:0];
      end
   end

   // ---------------- stages 2-3: table read, sign, coefficient product ----------------
   logic signed [ssp_pkg::PROD_W-1:0] x_prod_ff [ssp_pkg::TERMS];
   logic signed [ssp_pkg::PROD_W-1:0] y_prod_ff [ssp_pkg::TERMS];

   for (genvar k = 0; k < ssp_pkg::TERMS; k++) begin : g_harm
      logic        [ssp_pkg::PHASE_W-1:0] x_ang, y_ang;
      logic        [ssp_pkg::SINE_W-1:0]  x_sin, y_sin;
      logic                               x_neg_ff, y_neg_ff;
      logic signed [ssp_pkg::SINE_W:0]    x_sv, y_sv;

      // harmonic k+1: angle multiplies, wrapping at 2pi
      assign x_ang = ssp_pkg::PHASE_W'(x_base_ff * ssp_pkg::PHASE_W'(k + 1));
      assign y_ang = ssp_pkg::PHASE_W'(y_base_ff * ssp_pkg::PHASE_W'(k + 1));

      ssp_sine_rom u_rom (
         .clock  (clock),
         .rd_en  (s2_en),
         .addr_a (ssp_pkg::sine_addr(x_ang)),
         .addr_b (ssp_pkg::sine_addr(y_ang)),
         .data_a (x_sin),
         .data_b (y_sin)
      );

      always_ff @(posedge clock) begin
         if (s2_en) begin
            x_neg_ff <= x_ang[ssp_pkg::PHASE_W-1];
            y_neg_ff <= y_ang[ssp_pkg::PHASE_W-1];
         end
      end

      assign x_sv = x_neg_ff ? -$signed({1'b0, x_sin}) : $signed({1'b0, x_sin});
      assign y_sv = y_neg_ff ? -$signed({1'b0, y_sin}) : $signed({1'b0, y_sin});

      always_ff @(posedge clock) begin
         if (s3_en) begin
            x_prod_ff[k] <= ssp_pkg::PROD_W'(x_coef_ff[k]) * ssp_pkg::PROD_W'(x_sv);
            y_prod_ff[k] <= ssp_pkg::PROD_W'(y_coef_ff[k]) * ssp_pkg::PROD_W'(y_sv);
         end
      end
   end

   // ---------------- stage 4: per-axis sums ----------------
   logic signed [ssp_pkg::SER_W-1:0] x_sum_in, y_sum_in, x_sum_ff, y_sum_ff;

   always_comb begin
      x_sum_in = '0;
      y_sum_in = '0;
      for (int k = 0; k < ssp_pkg::TERMS; k++) begin
         x_sum_in = x_sum_in + ssp_pkg::SER_W'(x_prod_ff[k]);
         y_sum_in = y_sum_in + ssp_pkg::SER_W'(y_prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         x_sum_ff <= x_sum_in;
         y_sum_ff <= y_sum_in;
      end
   end

   // ---------------- output stage: round to Q12.8 and saturate ----------------
   logic signed [ssp_pkg::TOT_W-1:0] total, rounded;
   logic signed [ssp_pkg::OUT_W-1:0] value_in, value_ff;

   assign total   = ssp_pkg::TOT_W'(x_sum_ff) + ssp_pkg::TOT_W'(y_sum_ff)
                  + ssp_pkg::TOT_W'(1 << (ssp_pkg::FRAC_SHIFT - 1));
   assign rounded = total >>> ssp_pkg::FRAC_SHIFT;

   always_comb begin
      if (rounded > ssp_pkg::TOT_W'(ssp_pkg::OUT_MAX)) begin
         value_in = ssp_pkg::OUT_W'(ssp_pkg::OUT_MAX);
      end else if (rounded < ssp_pkg::TOT_W'(ssp_pkg::OUT_MIN)) begin
         value_in = ssp_pkg::OUT_W'(ssp_pkg::OUT_MIN);
      end else begin
         value_in = rounded[ssp_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         value_ff <= value_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ssp_pkg::RSP_W - ssp_pkg::OUT_W){1'b0}}, value_ff};

endmodule

`default_nettype wire

@@ design/ssp_checker.sv @@
// Port-level checker for the sine-series pixel block, bound to the top level.
// Depends on separable_sine_series_pixel_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "separable_sine_series_pixel_defines.svh"

module ssp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic [ssp_pkg::RSP_W-1:0]      rsp_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [ssp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [ssp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [ssp_pkg::CSR_DATA_W-1:0] csr_prdata
);

   // stalled result beat must hold
   `SSP_ASSERT_RST(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "rsp beat changed while stalled")

   // pipeline empties on reset
   `SSP_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "rsp_tvalid high right after reset")

   // pad bits above the 20-bit value stay zero
   `SSP_ASSERT_RST(a_rsp_pad, rsp_tvalid |-> (rsp_tdata[23:20] == 4'd0), "rsp_tdata pad bits not zero")

   // the low 16 bits of a register read back what was just written to it
   `SSP_ASSERT_RST(a_csr_readback, (csr_psel && csr_penable && csr_pwrite) ##1 (csr_psel && !csr_pwrite && (csr_paddr == $past(csr_paddr))) |-> (csr_prdata[15:0] == $past(csr_pwdata[15:0])), "csr read-back mismatch")

endmodule

bind separable_sine_series_pixel ssp_checker u_ssp_checker (.*);

`default_nettype wire

@@ tb/tb_separable_sine_series_pixel.sv @@
`timescale 1ns / 1ps
// Self-checking bench for separable_sine_series_pixel: APB register setup and readback,
// pixel beats with random gaps and stalls, results checked against a local sine-series model.
// Depends on ssp_pkg and the block's RTL; reads no files.

module tb_separable_sine_series_pixel;

   localparam int HALF_PERIOD    = 2;
   localparam int ROM_DEPTH      = 1024;
   localparam int NUM_REGS       = 8;
   localparam int PIPE_STAGES    = 5;
   localparam int DIR_SETTINGS   = 6;
   localparam int DIR_CASES      = 22;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PIXELS   = 141;
   localparam int IDLE_LIMIT     = 2000;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

   typedef struct {
      int          setting;
      logic [11:0] row;
      logic [11:0] col;
      logic        typed;
      logic [19:0] value;
   } pixel_case_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   // [11:0] pixel_row, [23:12] pixel_col
   logic [ssp_pkg::REQ_W-1:0]      req_tdata   = '0;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   // [19:0] pixel_value, [23:20] zero
   logic [ssp_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [ssp_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [ssp_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [ssp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // value typed into the directed table rides along with the beat
   logic                  typed_beat  = 1'b0;
   logic [19:0]           typed_value = '0;

   int          sine_q15 [0:ROM_DEPTH];
   logic [31:0] cfg_regs [0:NUM_REGS-1] = '{default: '0};
   logic [31:0] staged_regs [0:NUM_REGS-1];
   logic [19:0] pending_pixels [$];

   int  mismatches       = 0;
   int  pixels_accepted  = 0;
   int  settings_applied = 0;
   int  quiet_cycles     = 0;
   int  sink_run         = 0;
   bit  steady_phase     = 1'b0;

   logic [31:0] directed_settings [0:DIR_SETTINGS-1][0:NUM_REGS-1] = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      '{32'h0, 32'h0, 32'h7FFF, 32'h8000, 32'h0001, 32'hFFFF, 32'h7FFF, 32'h8000},
      '{32'h10000, 32'h10000, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF},
      '{32'h1FFFF, 32'h1, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000},
      '{32'h8000, 32'h5555, 32'h0100, 32'hFF00, 32'h0080, 32'h8000, 32'h7FFF, 32'h0001},
      '{32'h10, 32'h20, 32'h1234, 32'hEDCC, 32'h0400, 32'hF000, 32'h0C00, 32'hFFFF}
   };

   pixel_case_type directed_cases [0:DIR_CASES-1] = '{
      // reset values: every sine weighted by zero
      '{0, 12'd0,    12'd0,    1'b1, 20'd0},
      '{0, 12'd4095, 12'd4095, 1'b1, 20'd0},
      '{0, 12'd4095, 12'd0,    1'b1, 20'd0},
      // zero phase steps: all angles stay at zero whatever the weights
      '{1, 12'd4095, 12'd4095, 1'b1, 20'd0},
      '{1, 12'd123,  12'd2048, 1'b1, 20'd0},
      '{1, 12'd0,    12'd0,    1'b1, 20'd0},
      // pi per unit, largest weights
      '{2, 12'd1,    12'd1,    1'b0, 20'd0},
      '{2, 12'd0,    12'd4095, 1'b0, 20'd0},
      '{2, 12'd4095, 12'd1,    1'b0, 20'd0},
      '{2, 12'd2,    12'd3,    1'b0, 20'd0},
      // step above pi wraps; most negative weights
      '{3, 12'd4095, 12'd4095, 1'b0, 20'd0},
      '{3, 12'd2048, 12'd2047, 1'b0, 20'd0},
      '{3, 12'd1,    12'd4095, 1'b0, 20'd0},
      // quarter turns on columns, sixth turns on rows
      '{4, 12'd2730, 12'd3,    1'b0, 20'd0},
      '{4, 12'd7,    12'd4094, 1'b0, 20'd0},
      '{4, 12'd1,    12'd1,    1'b0, 20'd0},
      '{4, 12'd3,    12'd2,    1'b0, 20'd0},
      // raster-like steps, coordinates past the raster
      '{5, 12'd0,    12'd4095, 1'b0, 20'd0},
      '{5, 12'd2047, 12'd2048, 1'b0, 20'd0},
      '{5, 12'd4095, 12'd4095, 1'b0, 20'd0},
      '{5, 12'd1024, 12'd3071, 1'b0, 20'd0},
      '{5, 12'd4095, 12'd0,    1'b0, 20'd0}
   };

   separable_sine_series_pixel dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Quarter-wave table: Taylor series in Q30, rounded to unsigned Q0.15.
   initial begin : sine_table
      longint unsigned x_q30;
      longint unsigned power;
      longint unsigned partial;
      longint unsigned rounded;
      for (int i = 0; i <= ROM_DEPTH; i++) begin
         x_q30   = (QUARTER_TURN_Q30 * longint'(i)) / ROM_DEPTH;
         power   = x_q30;
         partial = x_q30;
         for (int n = 1; n <= 8; n++) begin
            power = (power * x_q30) >> 30;
            power = (power * x_q30) >> 30;
            power = power / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               partial = partial - power;
            end else begin
               partial = partial + power;
            end
         end
         rounded     = (partial + 16384) >> 15;
         sine_q15[i] = (rounded > 32767) ? 32767 : int'(rounded);
      end
   end

   function automatic logic [19:0] predict_pixel(input logic [11:0] row, input logic [11:0] col);
      longint      acc;
      longint      sum_q88;
      logic [16:0] step;
      logic [11:0] coord;
      logic [16:0] angle;
      int          base;
      int          sine;
      acc = 0;
      for (int axis = 0; axis < 2; axis++) begin
         step  = (axis == 0) ? cfg_regs[ssp_pkg::REG_X_STEP][16:0]
                             : cfg_regs[ssp_pkg::REG_Y_STEP][16:0];
         coord = (axis == 0) ? col : row;
         base  = (axis == 0) ? int'(ssp_pkg::REG_X_COEF1) : int'(ssp_pkg::REG_Y_COEF1);
         for (int k = 1; k <= ssp_pkg::TERMS; k++) begin
            angle = 17'(longint'(k) * longint'(step) * longint'(coord));
            // odd quadrants read the table mirrored, the upper half negates
            sine = angle[15] ? sine_q15[ROM_DEPTH - int'(angle[14:5])]
                             : sine_q15[int'(angle[14:5])];
            if (angle[16]) begin
               sine = -sine;
            end
            acc += longint'($signed(cfg_regs[base + k - 1][15:0])) * longint'(sine);
         end
      end
      sum_q88 = (acc + 16384) >>> 15;
      if (sum_q88 > ssp_pkg::OUT_MAX) begin
         sum_q88 = ssp_pkg::OUT_MAX;
      end
      if (sum_q88 < ssp_pkg::OUT_MIN) begin
         sum_q88 = ssp_pkg::OUT_MIN;
      end
      return sum_q88[19:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s at %0t ns: got 0x%0h, expected 0x%0h", what, $time, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      logic [19:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = typed_beat ? typed_value : predict_pixel(req_tdata[11:0], req_tdata[23:12]);
            pending_pixels = {pending_pixels, want};
            pixels_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("pixel_value, no beat outstanding", 32'(rsp_tdata), '0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata !== {4'b0, want}) begin
                  report_mismatch("pixel_value", 32'(rsp_tdata), {12'b0, want});
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat on any port for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: alternating ready runs and stalls, mostly short, some long.
   always @(negedge clock) begin : sink_pacing
      if (sink_run > 0) begin
         sink_run--;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         sink_run = (($urandom_range(0, 4) == 0) ? $urandom_range(6, 40)
                                                 : $urandom_range(1, 3)) - 1;
      end else begin
         rsp_tready <= 1'b1;
         sink_run = (($urandom_range(0, 9) < 3) ? $urandom_range(30, 200)
                                                : $urandom_range(1, 8)) - 1;
      end
   end

   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_phase || roll < 65) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [16:0] random_step();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 17'h10000;
         2: return 17'h1FFFF;
         3: return 17'(65536 / $urandom_range(1, 4095));
         default: return 17'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] random_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                             input logic typed, input logic [19:0] value);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata   <= {col, row};
      typed_beat  <= typed;
      typed_value <= value;
      req_tvalid  <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic csr_access(input logic is_write, input ssp_pkg::reg_idx_type index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= ssp_pkg::CSR_ADDR_W'(4 * int'(index));
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Writes every register from staged_regs, then reads all of them back.
   task automatic apply_staged();
      ssp_pkg::reg_idx_type index;
      logic [31:0]          got;
      logic [31:0]          width_mask;
      for (int i = 0; i < NUM_REGS; i++) begin
         index = ssp_pkg::reg_idx_type'(i);
         csr_access(1'b1, index, staged_regs[i], got);
         cfg_regs[i] = staged_regs[i];
      end
      for (int i = 0; i < NUM_REGS; i++) begin
         index      = ssp_pkg::reg_idx_type'(i);
         width_mask = (index == ssp_pkg::REG_X_STEP || index == ssp_pkg::REG_Y_STEP)
                      ? 32'h1FFFF : 32'hFFFF;
         csr_access(1'b0, index, '0, got);
         if ((got & width_mask) !== (cfg_regs[i] & width_mask)) begin
            report_mismatch($sformatf("readback %s", index.name()), got & width_mask,
                            cfg_regs[i] & width_mask);
         end
      end
      settings_applied++;
   endtask

   initial begin : stimulus
      int prev_setting;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      prev_setting = -1;
      for (int i = 0; i < DIR_CASES; i++) begin
         if (directed_cases[i].setting != prev_setting) begin
            wait_until_drained();
            prev_setting = directed_cases[i].setting;
            for (int r = 0; r < NUM_REGS; r++) begin
               staged_regs[r] = directed_settings[prev_setting][r];
            end
            apply_staged();
         end
         send_pixel(directed_cases[i].row, directed_cases[i].col,
                    directed_cases[i].typed, directed_cases[i].value);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_drained();
         // upper pwdata bits carry junk; the block keeps only the register width
         for (int r = 0; r < NUM_REGS; r++) begin
            if (r == ssp_pkg::REG_X_STEP || r == ssp_pkg::REG_Y_STEP) begin
               staged_regs[r] = {15'($urandom), random_step()};
            end else begin
               staged_regs[r] = {16'($urandom), random_coef()};
            end
         end
         apply_staged();
         steady_phase = (p % 3 == 1);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (p == 3 && n == PHASE_PIXELS / 2) begin
               wait_until_drained();
            end
            send_pixel(random_coord(), random_coord(), 1'b0, '0);
         end
      end

      wait_until_drained();
      repeat (4 * PIPE_STAGES) @(posedge clock);
      $display("Covered %0d pixels under %0d register settings with readback,",
               pixels_accepted, settings_applied);
      $display("random gaps on req and stalls on rsp; %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ separable_sine_series_pixel.f @@
+incdir+design
design/ssp_pkg.sv
design/ssp_sine_rom.sv
design/separable_sine_series_pixel.sv
design/ssp_checker.sv
tb/tb_separable_sine_series_pixel.sv
